// File: src/rgb2yuv_pkg.sv
// types, constants and helpers for the rgb to yuv 4:2:0 converter
// no dependencies; imported by rgb_to_yuv420_converter
package rgb2yuv_pkg;

    // geometry limits and register reset values
    localparam int unsigned CNT_W      = 12;
    localparam int unsigned CFG_W      = 13;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam logic [CFG_W-1:0] MAX_DIM       = 13'd4096;
    localparam logic [CFG_W-1:0] WIDTH_RESET   = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET  = 13'd480;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // bt.601 coefficients
    localparam logic [15:0] COEF_Y_R  = 16'd66;
    localparam logic [15:0] COEF_Y_G  = 16'd129;
    localparam logic [15:0] COEF_Y_B  = 16'd25;
    localparam logic [7:0]  Y_OFFSET  = 8'd16;
    localparam logic [15:0] COEF_U_R  = 16'd38;
    localparam logic [15:0] COEF_U_G  = 16'd74;
    localparam logic [15:0] COEF_UV_M = 16'd112;
    localparam logic [15:0] COEF_V_G  = 16'd94;
    localparam logic [15:0] COEF_V_B  = 16'd18;
    // 128 << 8, lifts the chroma sum to non-negative before the shift
    localparam logic [15:0] C_BIAS    = 16'h8000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       chroma_valid;
        logic       line_end;
        logic       frame_end;
    } t_result;

    // last position for a dimension: zero counts as one, above max as max
    function automatic logic [CNT_W-1:0] last_pos(input logic [CFG_W-1:0] dim);
        logic [CFG_W-1:0] d;
        d = dim;
        if (dim == '0) begin
            d = 13'd1;
        end else if (dim > MAX_DIM) begin
            d = MAX_DIM;
        end
        return CNT_W'(d - 13'd1);
    endfunction

endpackage

// File: src/rgb_to_yuv420_converter.sv
// rgb to bt.601 studio-range yuv 4:2:0 converter, top level
// depends on rgb2yuv_pkg
//
// Usage
// - input channel: i_in_valid / i_pixel, back-pressure on o_in_stall; an item
//   is taken at a clock edge with i_in_valid high and o_in_stall low
// - output channel: o_out_valid / o_result, back-pressure on i_out_stall
// - one result item per input pixel: luma always, chroma on even column of an
//   even line (zero otherwise), line and frame end flags from the internal
//   column and line counters, which wrap at the end of the frame
// - config port: i_cfg_we with i_cfg_index (0 width, 1 height) and i_cfg_data;
//   write only while no item is in flight
// Timing
// - an input register holds the pixel and its position flags, and the
//   arithmetic sits between it and the result register
// - throughput one item per cycle; while the receiver stalls, the result
//   register holds and the input register fills, then o_in_stall rises
// Reset
// - synchronous active low: counters cleared, both stages emptied,
//   width 640 and height 480
module rgb_to_yuv420_converter
    import rgb2yuv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_pixel               i_pixel,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_line, n_line;

    logic    r_s1_valid;
    t_pixel  r_s1_pixel;
    logic    r_s1_cvalid;
    logic    r_s1_lend;
    logic    r_s1_fend;

    logic    r_out_valid;
    t_result r_out, n_out;

    logic             out_load;
    logic             s1_load;
    logic             in_accept;
    logic [CNT_W-1:0] col_last;
    logic [CNT_W-1:0] line_last;
    logic             at_lend;
    logic             at_llast;
    logic [15:0]      y_sum;
    logic [15:0]      u_sum;
    logic [15:0]      v_sum;
    logic [15:0]      r16, g16, b16;

    // handshake between the two stages
    assign out_load    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !out_load;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign s1_load     = !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position of the incoming pixel and next counter values
    always_comb begin
        col_last  = last_pos(r_width);
        line_last = last_pos(r_height);
        at_lend   = r_col >= col_last;
        at_llast  = r_line >= line_last;
        n_col     = r_col + 12'd1;
        n_line    = r_line;
        if (at_lend) begin
            n_col  = '0;
            n_line = at_llast ? '0 : r_line + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else if (in_accept) begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

    // input register: pixel plus position flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pixel  <= i_pixel;
            r_s1_cvalid <= !r_col[0] && !r_line[0];
            r_s1_lend   <= at_lend;
            r_s1_fend   <= at_lend && at_llast;
        end
    end

    // colour matrix; chroma sums are biased so that bits 15:8 give the result
    always_comb begin
        r16   = {8'd0, r_s1_pixel.red};
        g16   = {8'd0, r_s1_pixel.green};
        b16   = {8'd0, r_s1_pixel.blue};
        y_sum = COEF_Y_R * r16 + COEF_Y_G * g16 + COEF_Y_B * b16;
        u_sum = C_BIAS - COEF_U_R * r16 - COEF_U_G * g16 + COEF_UV_M * b16;
        v_sum = C_BIAS + COEF_UV_M * r16 - COEF_V_G * g16 - COEF_V_B * b16;
        n_out.luma         = y_sum[15:8] + Y_OFFSET;
        n_out.chroma_blue  = r_s1_cvalid ? u_sum[15:8] : 8'd0;
        n_out.chroma_red   = r_s1_cvalid ? v_sum[15:8] : 8'd0;
        n_out.chroma_valid = r_s1_cvalid;
        n_out.line_end     = r_s1_lend;
        n_out.frame_end    = r_s1_fend;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    // a frame end is always also a line end
    a_fend_lend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.frame_end |-> o_result.line_end)
        else $error("frame end without line end");

    // chroma fields are zero when chroma is not valid
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result.chroma_valid
        |-> o_result.chroma_blue == 8'd0 && o_result.chroma_red == 8'd0)
        else $error("chroma not zero on a pixel without chroma");

    // an item in the input register is kept while the result register is blocked
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && i_out_stall |=> r_s1_valid)
        else $error("item lost from input register");

endmodule
